[design/assert_macros.svh]
// Assertion macros shared by the scalar register file RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication or plain property on every rising clock edge out of reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");

// Check that a condition never holds out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

[design/srfz_pkg.sv]
// Types, register indexes, the reserved-index check and the reset-value function of the scalar register file.
// Depends on nothing; used by srfz_mem and the top level.
package srfz_pkg;

    localparam int NUM_SCALAR_REGS = 256;
    localparam int WAVE_LANES      = 64;
    localparam int IDX_W           = $clog2(NUM_SCALAR_REGS);
    localparam int LANE_W          = $clog2(WAVE_LANES);
    localparam int DATA_W          = 32;

    localparam logic [IDX_W-1:0] IDX_VCC_LO  = 8'd106;
    localparam logic [IDX_W-1:0] IDX_VCC_HI  = 8'd107;
    localparam logic [IDX_W-1:0] IDX_EXEC_LO = 8'd126;
    localparam logic [IDX_W-1:0] IDX_EXEC_HI = 8'd127;
    localparam logic [IDX_W-1:0] IDX_VCCZ    = 8'd251;
    localparam logic [IDX_W-1:0] IDX_EXECZ   = 8'd252;

    localparam logic [DATA_W-1:0] FLOAT_CONSTS [8] = '{
        32'h3F00_0000, 32'hBF00_0000, 32'h3F80_0000, 32'hBF80_0000,
        32'h4000_0000, 32'hC000_0000, 32'h4080_0000, 32'hC080_0000
    };

    typedef enum logic {
        FUNC_READ  = 1'b0,
        FUNC_WRITE = 1'b1
    } func_t;

    typedef struct packed {
        func_t              func;
        logic [IDX_W-1:0]   reg_index;
        logic [DATA_W-1:0]  write_value;
        logic [LANE_W-1:0]  lane;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0]  read_value;
        logic               lane_active;
        logic               bad_index;
    } out_item_t;

    // One memory access per transfer: an optional read and an optional write.
    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic [IDX_W-1:0]   addr;
        logic [DATA_W-1:0]  wr_data;
    } mem_req_t;

    function automatic logic is_reserved(input logic [IDX_W-1:0] idx);
        logic res;
        case (idx) inside
            8'd104, 8'd105, 8'd125, [8'd209:8'd239], [8'd248:8'd250], 8'd254: res = 1'b1;
            default: res = 1'b0;
        endcase
        return res;
    endfunction

    // Value an entry holds after reset until it is first written.
    function automatic logic [DATA_W-1:0] reset_value(input logic [IDX_W-1:0] idx);
        logic [DATA_W-1:0] val;
        case (idx) inside
            [8'd128:8'd192]: val = DATA_W'(idx - 8'd128);
            [8'd193:8'd208]: val = DATA_W'(192) - DATA_W'(idx);
            [8'd240:8'd247]: val = FLOAT_CONSTS[idx[2:0]];
            default:         val = '0;
        endcase
        return val;
    endfunction

endpackage

[design/srfz_mem.sv]
// Synchronous 256 x 32 scalar register store with per-entry written bits.
// Depends on srfz_pkg; unwritten entries return their inline-constant reset value.
module srfz_mem (
    input  logic                             clk,
    input  logic                             rst_n,
    input  srfz_pkg::mem_req_t               req,
    output logic [srfz_pkg::DATA_W-1:0]      rd_data
);
    import srfz_pkg::*;

    logic [DATA_W-1:0]          mem [NUM_SCALAR_REGS];
    logic [NUM_SCALAR_REGS-1:0] written_reg;
    logic [DATA_W-1:0]          mem_q_reg;
    logic [DATA_W-1:0]          rst_q_reg;
    logic                       written_q_reg;

    // Storage and registered read port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            mem_q_reg <= mem[req.addr];
            rst_q_reg <= reset_value(req.addr);
        end
    end

    // Track which entries have been written since reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg   <= '0;
            written_q_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                written_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                written_q_reg <= written_reg[req.addr];
            end
        end
    end

    assign rd_data = written_q_reg ? mem_q_reg : rst_q_reg;

endmodule

[design/scalar_register_file_zero_flags_top.sv]
// Top level of the scalar register file with inline constants and zero flags.
// Depends on srfz_pkg, srfz_mem and assert_macros.svh.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one read or write of a
//   scalar register plus a lane number. Output channel out_valid / out_stall /
//   out_data returns exactly one result per input transfer, in order.
//   A transfer happens at a rising edge with valid high and stall low.
//
// Pipeline and throughput:
//   A result is presented after the store read at the transfer edge and the
//   output register, which loads when the read stage advances. One item per
//   cycle is sustained while out_stall stays low, set by the single store
//   port, which takes one read or one write each cycle. Writes land in the
//   store at their transfer edge, so the very next item already reads them.
//
// Reset:
//   rst_n clears EXEC, VCC, the pipeline valid flags and the store's written
//   bits; unwritten entries read as their inline constants (0..64, -1..-16,
//   float +-0.5/1/2/4), VCCZ and EXECZ as one, the rest zero; no clearing pass.
//
// Stall:
//   With out_stall high the result holds on out_data; one more item may sit in
//   the read stage, after which in_stall rises until the output drains.
`include "assert_macros.svh"

module scalar_register_file_zero_flags_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  srfz_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output srfz_pkg::out_item_t   out_data
);
    import srfz_pkg::*;

    // Architected masks.
    logic [WAVE_LANES-1:0] exec_reg;
    logic [WAVE_LANES-1:0] exec_next;
    logic [WAVE_LANES-1:0] vcc_reg;
    logic [WAVE_LANES-1:0] vcc_next;

    // Read stage: waits for the store's registered data.
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_use_mem_reg;
    logic [DATA_W-1:0]     s1_value_reg;
    logic                  s1_active_reg;
    logic                  s1_bad_reg;

    // Output register.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    out_item_t             out_reg;

    logic                  accept;
    logic                  s1_advance;
    logic                  bad;
    logic                  special;
    logic [DATA_W-1:0]     special_value;
    logic [DATA_W-1:0]     mem_rd_data;
    mem_req_t              mem_req;

    // Handshake: the read stage moves on when the output register is free or
    // being emptied; a new item enters when the read stage moves or is empty.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign accept     = in_valid && !in_stall;

    assign bad = is_reserved(in_data.reg_index);

    // Decode the indexes served from the masks instead of the store.
    always_comb
    begin
        special       = 1'b1;
        special_value = '0;
        case (in_data.reg_index)
            IDX_VCC_LO:  special_value = vcc_reg[DATA_W-1:0];
            IDX_VCC_HI:  special_value = vcc_reg[2*DATA_W-1:DATA_W];
            IDX_EXEC_LO: special_value = exec_reg[DATA_W-1:0];
            IDX_EXEC_HI: special_value = exec_reg[2*DATA_W-1:DATA_W];
            IDX_VCCZ:    special_value = DATA_W'(vcc_reg == '0);
            IDX_EXECZ:   special_value = DATA_W'(exec_reg == '0);
            default:     special = 1'b0;
        endcase
    end

    // Store access: reads and writes both go out at the transfer edge.
    always_comb
    begin
        mem_req.addr    = in_data.reg_index;
        mem_req.wr_data = in_data.write_value;
        mem_req.rd_en   = accept && !bad && !special && (in_data.func == FUNC_READ);
        mem_req.wr_en   = accept && !bad && !special && (in_data.func == FUNC_WRITE);
    end

    srfz_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    // Mask updates: replace one 32-bit half on a write to its index.
    always_comb
    begin
        exec_next = exec_reg;
        vcc_next  = vcc_reg;
        if (accept && !bad && (in_data.func == FUNC_WRITE))
        begin
            case (in_data.reg_index)
                IDX_VCC_LO:  vcc_next[DATA_W-1:0]           = in_data.write_value;
                IDX_VCC_HI:  vcc_next[2*DATA_W-1:DATA_W]    = in_data.write_value;
                IDX_EXEC_LO: exec_next[DATA_W-1:0]          = in_data.write_value;
                IDX_EXEC_HI: exec_next[2*DATA_W-1:DATA_W]   = in_data.write_value;
                default:     ;
            endcase
        end
    end

    // Pipeline occupancy.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_reg      <= '0;
            vcc_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            exec_reg      <= exec_next;
            vcc_reg       <= vcc_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of the read stage: capture lane bit before this item's write.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_use_mem_reg <= mem_req.rd_en;
            s1_value_reg   <= (!bad && special && (in_data.func == FUNC_READ))
                              ? special_value : '0;
            s1_active_reg  <= exec_reg[in_data.lane];
            s1_bad_reg     <= bad;
        end
    end

    // Output payload: hold while stalled, load when the read stage advances.
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_reg.read_value  <= s1_use_mem_reg ? mem_rd_data : s1_value_reg;
            out_reg.lane_active <= s1_active_reg;
            out_reg.bad_index   <= s1_bad_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A write to the low EXEC word shows up in the mask in the following cycle.
    `ASSERT_PROP(a_exec_lo_write, clk, rst_n,
        (accept && (in_data.func == FUNC_WRITE) && (in_data.reg_index == IDX_EXEC_LO))
        |=> (exec_reg[DATA_W-1:0] == $past(in_data.write_value)))

    // A held read stage must block the input side.
    `ASSERT_PROP(a_s1_hold_stalls, clk, rst_n,
        (s1_valid_reg && out_valid_reg && out_stall) |-> in_stall)

    // An item held in the read stage is not dropped.
    `ASSERT_PROP(a_s1_no_loss, clk, rst_n,
        (s1_valid_reg && out_valid_reg && out_stall) |=> s1_valid_reg)

    // Reserved indexes always return zero data.
    `ASSERT_NEVER(a_bad_zero, clk, rst_n,
        out_valid_reg && out_reg.bad_index && (out_reg.read_value != '0))

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for scalar_register_file_zero_flags_top: a directed table, then random
// transfers. Results are compared with the table or a shadow register file. Depends on srfz_pkg.
module testbench;
    import srfz_pkg::*;

    // Cycles with no transfer on either channel before the run is abandoned.
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int MAX_PRINTED   = 50;

    // Single-precision patterns of 0.5, -0.5, 1, -1, 2, -2, 4, -4 at indices 240..247.
    localparam logic [31:0] HALF_ONE_TWO_FOUR [8] = '{
        32'h3F00_0000, 32'hBF00_0000, 32'h3F80_0000, 32'hBF80_0000,
        32'h4000_0000, 32'hC000_0000, 32'h4080_0000, 32'hC080_0000
    };

    // One row of the directed table; want is used only when typed is set.
    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } access_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    // Shadow state of the register file.
    logic [31:0] shadow_regs [NUM_SCALAR_REGS];
    logic [63:0] shadow_exec;
    logic [63:0] shadow_vcc;

    out_item_t   expected_results [$];
    access_row_t directed_rows [$];

    int  mismatch_count = 0;
    int  results_seen = 0;
    int  idle_cycles = 0;
    int  reads_sent = 0;
    int  writes_sent = 0;
    int  reserved_sent = 0;
    int  zero_flag_reads = 0;
    bit  calm_stretch = 1'b0;

    scalar_register_file_zero_flags_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Reserved indices: accesses are flagged and leave the state alone.
    function automatic bit index_reserved(input logic [7:0] idx);
        return idx == 8'd104 || idx == 8'd105 || idx == 8'd125 ||
               (idx >= 8'd209 && idx <= 8'd239) ||
               (idx >= 8'd248 && idx <= 8'd250) || idx == 8'd254;
    endfunction

    // Load the inline constants and clear both masks, as reset does.
    task automatic load_inline_constants();
        for (int i = 0; i < NUM_SCALAR_REGS; i++) begin
            if (i >= 128 && i <= 192)
                shadow_regs[i] = 32'(i - 128);
            else if (i >= 193 && i <= 208)
                shadow_regs[i] = 32'(192 - i);
            else if (i >= 240 && i <= 247)
                shadow_regs[i] = HALF_ONE_TWO_FOUR[i - 240];
            else
                shadow_regs[i] = '0;
        end
        shadow_exec = '0;
        shadow_vcc  = '0;
    endtask

    // Apply one access to the shadow file and return the result it must produce.
    // The lane bit is taken before the write lands.
    function automatic out_item_t apply_access(input in_item_t item);
        out_item_t res;
        res = '0;
        res.lane_active = shadow_exec[item.lane];
        res.bad_index   = index_reserved(item.reg_index);
        if (!res.bad_index) begin
            if (item.func == FUNC_READ) begin
                case (item.reg_index)
                    IDX_VCC_LO:  res.read_value = shadow_vcc[31:0];
                    IDX_VCC_HI:  res.read_value = shadow_vcc[63:32];
                    IDX_EXEC_LO: res.read_value = shadow_exec[31:0];
                    IDX_EXEC_HI: res.read_value = shadow_exec[63:32];
                    IDX_VCCZ:    res.read_value = {31'b0, shadow_vcc == 64'd0};
                    IDX_EXECZ:   res.read_value = {31'b0, shadow_exec == 64'd0};
                    default:     res.read_value = shadow_regs[item.reg_index];
                endcase
            end else begin
                case (item.reg_index)
                    IDX_VCC_LO:  shadow_vcc[31:0]   = item.write_value;
                    IDX_VCC_HI:  shadow_vcc[63:32]  = item.write_value;
                    IDX_EXEC_LO: shadow_exec[31:0]  = item.write_value;
                    IDX_EXEC_HI: shadow_exec[63:32] = item.write_value;
                    IDX_VCCZ, IDX_EXECZ: ;
                    default:     shadow_regs[item.reg_index] = item.write_value;
                endcase
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] mismatch on result %0d, %s: got %h, expected %h",
                     $realtime, results_seen, what, got, want);
        mismatch_count++;
    endtask

    task automatic add_row(input func_t f, input logic [7:0] idx, input logic [31:0] val,
                           input logic [5:0] lane, input bit typed,
                           input logic [31:0] rv, input logic la, input logic bad);
        access_row_t row;
        row.item.func        = f;
        row.item.reg_index   = idx;
        row.item.write_value = val;
        row.item.lane        = lane;
        row.typed            = typed;
        row.want.read_value  = rv;
        row.want.lane_active = la;
        row.want.bad_index   = bad;
        directed_rows.push_back(row);
    endtask

    // Random access, biased toward the mask words, zero flags, reserved
    // indices and the inline constants, where the file does something special.
    function automatic in_item_t make_random_item();
        in_item_t    item;
        int unsigned pick;
        item.func = ($urandom_range(1) == 1) ? FUNC_WRITE : FUNC_READ;
        pick = $urandom_range(99);
        if (pick < 30) begin
            case ($urandom_range(5))
                0:       item.reg_index = IDX_VCC_LO;
                1:       item.reg_index = IDX_VCC_HI;
                2:       item.reg_index = IDX_EXEC_LO;
                3:       item.reg_index = IDX_EXEC_HI;
                4:       item.reg_index = IDX_VCCZ;
                default: item.reg_index = IDX_EXECZ;
            endcase
        end else if (pick < 42) begin
            case ($urandom_range(5))
                0:       item.reg_index = 8'd104;
                1:       item.reg_index = 8'd105;
                2:       item.reg_index = 8'd125;
                3:       item.reg_index = 8'($urandom_range(239, 209));
                4:       item.reg_index = 8'($urandom_range(250, 248));
                default: item.reg_index = 8'd254;
            endcase
        end else if (pick < 62) begin
            item.reg_index = 8'($urandom_range(247, 128));
        end else begin
            item.reg_index = 8'($urandom);
        end
        pick = $urandom_range(99);
        // Zero writes to the mask words often, so both zero flags keep toggling.
        if (pick < 30)
            item.write_value = '0;
        else if (pick < 40)
            item.write_value = '1;
        else if (pick < 50)
            item.write_value = 32'd1 << $urandom_range(31);
        else
            item.write_value = $urandom;
        item.lane = 6'($urandom);
        return item;
    endfunction

    // Offer one item on the input channel and wait for its transfer.
    // Enter and leave at a falling edge; valid stays high between back-to-back items.
    task automatic send_item(input in_item_t item, input bit typed, input out_item_t want);
        out_item_t predicted;
        while (!calm_stretch && $urandom_range(99) < 37) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // Transfer taken at this edge: advance the shadow file.
        predicted = apply_access(item);
        expected_results.push_back(typed ? want : predicted);
        if (index_reserved(item.reg_index))
            reserved_sent++;
        else if (item.func == FUNC_WRITE)
            writes_sent++;
        else begin
            reads_sent++;
            if (item.reg_index == IDX_VCCZ || item.reg_index == IDX_EXECZ)
                zero_flag_reads++;
        end
        @(negedge clk);
    endtask

    // Receiver: stall at random, except through the calm stretch.
    always @(negedge clk) begin
        if (rst_n)
            out_stall <= !calm_stretch && ($urandom_range(99) < 37);
    end

    // Check every result transfer against the oldest expectation.
    always @(posedge clk) begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", out_data.read_value, '0);
            end else begin
                want = expected_results.pop_front();
                if (out_data.read_value !== want.read_value)
                    report_mismatch("read_value", out_data.read_value, want.read_value);
                if (out_data.lane_active !== want.lane_active)
                    report_mismatch("lane_active", 32'(out_data.lane_active),
                                    32'(want.lane_active));
                if (out_data.bad_index !== want.bad_index)
                    report_mismatch("bad_index", 32'(out_data.bad_index),
                                    32'(want.bad_index));
            end
            results_seen++;
        end
    end

    // Watchdog: drop the run when neither channel moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        out_item_t unused;
        unused = '0;
        load_inline_constants();

        // Inline constants at both ends of each range, straight after reset.
        add_row(FUNC_READ,  8'd128, '0, 6'd0,  1, 32'd0,         1'b0, 1'b0);
        add_row(FUNC_READ,  8'd192, '0, 6'd63, 1, 32'd64,        1'b0, 1'b0);
        add_row(FUNC_READ,  8'd193, '0, 6'd0,  1, 32'hFFFF_FFFF, 1'b0, 1'b0);
        add_row(FUNC_READ,  8'd208, '0, 6'd0,  1, 32'hFFFF_FFF0, 1'b0, 1'b0);
        add_row(FUNC_READ,  8'd240, '0, 6'd0,  1, 32'h3F00_0000, 1'b0, 1'b0);
        add_row(FUNC_READ,  8'd247, '0, 6'd0,  1, 32'hC080_0000, 1'b0, 1'b0);
        // Both zero flags read as set while the masks are clear.
        add_row(FUNC_READ,  IDX_VCCZ,  '0, 6'd0, 1, 32'd1, 1'b0, 1'b0);
        add_row(FUNC_READ,  IDX_EXECZ, '0, 6'd0, 1, 32'd1, 1'b0, 1'b0);
        add_row(FUNC_READ,  8'd0,   '0, 6'd63, 1, 32'd0, 1'b0, 1'b0);
        // Reserved indices: flagged, nothing stored, nothing read.
        add_row(FUNC_READ,  8'd104, '0, 6'd0, 1, 32'd0, 1'b0, 1'b1);
        add_row(FUNC_WRITE, 8'd254, '1, 6'd0, 1, 32'd0, 1'b0, 1'b1);
        // Fill the low EXEC word; the lane bit is reported before the write.
        add_row(FUNC_WRITE, IDX_EXEC_LO, '1, 6'd0, 1, 32'd0, 1'b0, 1'b0);
        add_row(FUNC_READ,  IDX_EXECZ,   '0, 6'd0, 1, 32'd0, 1'b1, 1'b0);
        add_row(FUNC_READ,  IDX_EXEC_HI, '0, 6'd63, 1, 32'd0, 1'b0, 1'b0);
        add_row(FUNC_WRITE, IDX_EXEC_HI, 32'h8000_0000, 6'd63, 1, 32'd0, 1'b0, 1'b0);
        add_row(FUNC_READ,  IDX_EXEC_HI, '0, 6'd63, 1, 32'h8000_0000, 1'b1, 1'b0);
        // One VCC bit clears VCCZ.
        add_row(FUNC_WRITE, IDX_VCC_LO, 32'd1, 6'd5, 1, 32'd0, 1'b1, 1'b0);
        add_row(FUNC_READ,  IDX_VCCZ,   '0, 6'd40, 1, 32'd0, 1'b0, 1'b0);
        // A write to a zero flag has no visible effect.
        add_row(FUNC_WRITE, IDX_EXECZ, 32'd1, 6'd31, 0, '0, 1'b0, 1'b0);
        add_row(FUNC_READ,  IDX_EXECZ, '0,    6'd31, 0, '0, 1'b0, 1'b0);
        // Inline constants and index 255 take writes like plain storage.
        add_row(FUNC_WRITE, 8'd128, 32'hDEAD_BEEF, 6'd1, 0, '0, 1'b0, 1'b0);
        add_row(FUNC_READ,  8'd128, '0, 6'd2, 0, '0, 1'b0, 1'b0);
        add_row(FUNC_WRITE, 8'd255, '1, 6'd3, 0, '0, 1'b0, 1'b0);
        add_row(FUNC_READ,  8'd255, '0, 6'd4, 0, '0, 1'b0, 1'b0);
        // Clear EXEC again: EXECZ returns to one.
        add_row(FUNC_WRITE, IDX_EXEC_LO, '0, 6'd0, 0, '0, 1'b0, 1'b0);
        add_row(FUNC_WRITE, IDX_EXEC_HI, '0, 6'd0, 0, '0, 1'b0, 1'b0);
        add_row(FUNC_READ,  IDX_EXECZ,   '0, 6'd63, 1, 32'd1, 1'b0, 1'b0);

        // Hold reset, then release it away from the rising edge.
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Run a long stretch with neither side idling.
            calm_stretch = (n >= 400 && n < 600);
            send_item(make_random_item(), 0, unused);
        end
        calm_stretch = 1'b0;
        in_valid <= 1'b0;

        // Drain: the watchdog covers a result that never comes.
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d reads (%0d of zero flags), %0d writes, %0d reserved accesses",
                 reads_sent, zero_flag_reads, writes_sent, reserved_sent);
        $display("%0d results checked, %0d mismatches", results_seen, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
